### src/hplr_pkg.sv
// shared types, widths, pose landmark map and coefficient table for the head pose regressor
// no dependencies; used by hplr_ram users, hplr_div and head_pose_linear_regression
`default_nettype none

package hplr_pkg;

   localparam int IDX_W              = 8;
   localparam int COORD_W            = 16;
   localparam int ANGLE_W            = 16;
   localparam int STATUS_W           = 2;
   localparam int LANDMARK_COUNT     = 68;
   localparam int POSE_POINTS        = 7;
   localparam int SLOT_W             = 3;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int COEF_INT_BITS      = 8;
   localparam int COEF_ROWS          = 15;
   localparam int BIAS_ROW           = 14;
   localparam int ANGLES             = 3;
   localparam int ANGLE_FRAC         = 7;

   // sum of seven coordinates, seven times the span
   localparam int SUM_W  = 19;
   localparam int DEN_W  = 19;
   // 7*v - sum, signed
   localparam int NUM_W  = 20;
   localparam int NORM_FRAC = 16;
   localparam int NORM_W = 24;
   localparam int QUO_W  = NORM_W - 1;
   localparam int DVD_W  = NUM_W + NORM_FRAC;

   localparam longint COEF_SCALE = 1000000;

   localparam logic [IDX_W-1:0] POSE_INDEX [POSE_POINTS] =
      '{8'd36, 8'd39, 8'd42, 8'd45, 8'd30, 8'd48, 8'd54};

   // rows 0..6 x terms, 7..13 y terms, 14 bias; units of 1e-6
   localparam longint COEF_MICRO [COEF_ROWS][ANGLES] = '{
      '{139791, 27402800, 7026360},
      '{-2482070, 9593840, 6037580},
      '{1274020, 10479500, 6208010},
      '{1174060, 29188600, 1677680},
      '{306761, -103832000, 5662380},
      '{4786630, 17872600, -15362300},
      '{-5200160, 9294880, -11249500},
      '{-25170400, 10864900, -29487700},
      '{-5625720, 9087100, -12098200},
      '{-5197070, -8252510, 13396500},
      '{-23664300, -13134800, 29432200},
      '{67239000, 666896, 1843040},
      '{-2832230, 4563330, -15885000},
      '{-4749480, -3794540, 12798600},
      '{-16100000, 1471750, 4039410}
   };

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_SPAN = 2'd1,
      STATUS_MISSING   = 2'd2
   } status_type;

   typedef struct packed {
      logic                     hit;
      logic [SLOT_W-1:0]        slot;
   } slot_hit_type;

   typedef struct packed {
      logic                     done;
      logic signed [NORM_W-1:0] quo;
   } div_out_type;

   function automatic slot_hit_type slot_lookup(input logic [IDX_W-1:0] idx);
      slot_hit_type r;
      r.hit  = 1'b0;
      r.slot = '0;
      for (int i = 0; i < POSE_POINTS; i++) begin
         if (idx == POSE_INDEX[i]) begin
            r.hit  = 1'b1;
            r.slot = SLOT_W'(i);
         end
      end
      return r;
   endfunction

   // fixed-point coefficient, round half away from zero
   function automatic longint coef_q(input int row, input int col, input int frac);
      longint num;
      longint mag;
      longint q;
      num = COEF_MICRO[row][col] * (longint'(1) << frac);
      mag = (num < 0) ? -num : num;
      q   = (mag + COEF_SCALE / 2) / COEF_SCALE;
      return (num < 0) ? -q : q;
   endfunction

endpackage

`default_nettype wire

### src/hplr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module hplr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 7
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/hplr_div.sv
// radix-2 restoring divider for coordinate normalization, rounded and saturated
// depends on hplr_pkg
`default_nettype none

module hplr_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [hplr_pkg::NUM_W-1:0]  num,
   input  wire logic        [hplr_pkg::DEN_W-1:0]  den,
   output hplr_pkg::div_out_type                   res
);

   localparam int NUM_W  = hplr_pkg::NUM_W;
   localparam int DEN_W  = hplr_pkg::DEN_W;
   localparam int DVD_W  = hplr_pkg::DVD_W;
   localparam int QUO_W  = hplr_pkg::QUO_W;
   localparam int NORM_W = hplr_pkg::NORM_W;
   localparam int CNT_W  = $clog2(QUO_W + 1);

   logic [NUM_W-1:0]  mag;
   logic [DVD_W-1:0]  dvd;
   logic              sat;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              ge;
   logic [QUO_W-1:0]  quo_next;
   logic [NORM_W-1:0] res_mag;

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic              sat_ff, sat_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [NORM_W-1:0] val_ff, val_in;

   always_comb begin
      mag      = num[NUM_W-1] ? -num : num;
      dvd      = (DVD_W'(mag[NUM_W-2:0]) << hplr_pkg::NORM_FRAC) + DVD_W'(den >> 1);
      sat      = DEN_W'(dvd[DVD_W-1:QUO_W]) >= den;
      shifted  = {rem_ff, low_ff[QUO_W-1]};
      diff     = shifted - {1'b0, den};
      ge       = shifted >= {1'b0, den};
      quo_next = {quo_ff[QUO_W-2:0], ge};
      res_mag  = {1'b0, (sat_ff ? {QUO_W{1'b1}} : quo_next)};

      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = DEN_W'(dvd[DVD_W-1:QUO_W]);
         low_in  = dvd[QUO_W-1:0];
         quo_in  = '0;
         neg_in  = num[NUM_W-1];
         sat_in  = sat;
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         low_in = low_ff << 1;
         quo_in = quo_next;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            val_in  = neg_ff ? -res_mag : res_mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
   end

   assign res.done = done_ff;
   assign res.quo  = val_ff;

endmodule

`default_nettype wire

### src/head_pose_linear_regression.sv
// head pose regressor top: slot ram, sum/span pass, two dividers, three-column mac
// depends on hplr_pkg, hplr_ram, hplr_div
// non-final landmark beats are taken one per cycle; req_stall stays high from a final beat
// until its result is loaded: a missing pose point goes straight to the load, a zero span
// stops after the sum pass and span check, else a divide and mac per slot for all 7 slots, drain, load
// synchronous active-high reset clears control and the seen mask; slot ram is not cleared
`default_nettype none

module head_pose_linear_regression #(
   parameter int COEF_FRAC_BITS = hplr_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [hplr_pkg::IDX_W-1:0]         req_landmark_index,
   input  wire logic [hplr_pkg::COORD_W-1:0]       req_coord_x,
   input  wire logic [hplr_pkg::COORD_W-1:0]       req_coord_y,
   input  wire logic                               req_last_point,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [hplr_pkg::ANGLE_W-1:0]     rsp_pitch,
   output logic signed [hplr_pkg::ANGLE_W-1:0]     rsp_yaw,
   output logic signed [hplr_pkg::ANGLE_W-1:0]     rsp_roll,
   output logic        [hplr_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int COORD_W = hplr_pkg::COORD_W;
   localparam int PTS     = hplr_pkg::POSE_POINTS;
   localparam int SLOT_W  = hplr_pkg::SLOT_W;
   localparam int SUM_W   = hplr_pkg::SUM_W;
   localparam int DEN_W   = hplr_pkg::DEN_W;
   localparam int NUM_W   = hplr_pkg::NUM_W;
   localparam int NORM_W  = hplr_pkg::NORM_W;
   localparam int ANGLE_W = hplr_pkg::ANGLE_W;
   localparam int ANGLES  = hplr_pkg::ANGLES;
   localparam int ROWS    = hplr_pkg::COEF_ROWS;
   localparam int ROW_W   = $clog2(ROWS);
   localparam int COEF_W  = COEF_FRAC_BITS + hplr_pkg::COEF_INT_BITS;
   localparam int PROD_W  = NORM_W + COEF_W;
   localparam int ACC_W   = PROD_W + 4;
   localparam int SH      = hplr_pkg::NORM_FRAC + COEF_FRAC_BITS - hplr_pkg::ANGLE_FRAC;
   localparam int RAM_W   = 2 * COORD_W;

   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (SH - 1);
   localparam logic signed [ACC_W-1:0] ANG_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] ANG_MIN = -ACC_W'(32768);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SUM    = 9'b000000010,
      ST_SPAN   = 9'b000000100,
      ST_START  = 9'b000001000,
      ST_DIV    = 9'b000010000,
      ST_MAC_X  = 9'b000100000,
      ST_MAC_Y  = 9'b001000000,
      ST_DRAIN  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   logic signed [COEF_W-1:0] coef_tbl [ROWS][ANGLES];

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar c = 0; c < ANGLES; c++) begin : g_col
         assign coef_tbl[r][c] = COEF_W'(hplr_pkg::coef_q(r, c, COEF_FRAC_BITS));
      end
   end

   state_type                 state_ff, state_in;
   logic [SLOT_W-1:0]         cnt_ff, cnt_in;
   logic [PTS-1:0]            seen_ff, seen_in;
   logic [SUM_W-1:0]          sx_ff, sx_in;
   logic [SUM_W-1:0]          sy_ff, sy_in;
   logic [COORD_W-1:0]        ymin_ff, ymin_in;
   logic [COORD_W-1:0]        ymax_ff, ymax_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   hplr_pkg::status_type      status_ff, status_in;
   logic signed [PROD_W-1:0]  prod_ff [ANGLES];
   logic signed [PROD_W-1:0]  prod_in [ANGLES];
   logic                      prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]   acc_ff [ANGLES];
   logic signed [ACC_W-1:0]   acc_in [ANGLES];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_ang_ff [ANGLES];
   logic signed [ANGLE_W-1:0] rsp_ang_in [ANGLES];
   hplr_pkg::status_type      rsp_status_ff, rsp_status_in;

   hplr_pkg::slot_hit_type    hit;
   logic                      req_accept;
   logic                      store;
   logic [PTS-1:0]            seen_next;
   logic                      ram_we;
   logic                      ram_re;
   logic [SLOT_W-1:0]         ram_raddr;
   logic [RAM_W-1:0]          ram_rdata;
   logic [COORD_W-1:0]        rd_x;
   logic [COORD_W-1:0]        rd_y;
   logic [COORD_W-1:0]        span;
   logic signed [NUM_W-1:0]   num_x;
   logic signed [NUM_W-1:0]   num_y;
   logic                      div_start;
   hplr_pkg::div_out_type     res_x;
   hplr_pkg::div_out_type     res_y;
   logic [ROW_W-1:0]          coef_row;
   logic signed [NORM_W-1:0]  vec_sel;
   logic signed [ACC_W-1:0]   rnd [ANGLES];
   logic signed [ACC_W-1:0]   shr [ANGLES];
   logic signed [ANGLE_W-1:0] ang_sat [ANGLES];

   hplr_ram #(
      .WIDTH (RAM_W),
      .DEPTH (PTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (hit.slot),
      .wdata ({req_coord_x, req_coord_y}),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   hplr_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_x),
      .den   (den_ff),
      .res   (res_x)
   );

   hplr_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_y),
      .den   (den_ff),
      .res   (res_y)
   );

   always_comb begin
      rd_x  = ram_rdata[RAM_W-1:COORD_W];
      rd_y  = ram_rdata[COORD_W-1:0];
      span  = ymax_ff - ymin_ff;
      num_x = NUM_W'({rd_x, 3'b000}) - NUM_W'(rd_x) - NUM_W'(sx_ff);
      num_y = NUM_W'({rd_y, 3'b000}) - NUM_W'(rd_y) - NUM_W'(sy_ff);

      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && !req_stall;
      hit        = hplr_pkg::slot_lookup(req_landmark_index);
      store      = hit.hit && ({1'b0, req_landmark_index} <
                   (hplr_pkg::IDX_W + 1)'(hplr_pkg::LANDMARK_COUNT));
      seen_next  = seen_ff | (store ? (PTS'(1) << hit.slot) : '0);

      coef_row = (state_ff == ST_MAC_Y) ? ROW_W'(cnt_ff) + ROW_W'(PTS) : ROW_W'(cnt_ff);
      vec_sel  = (state_ff == ST_MAC_Y) ? res_y.quo : res_x.quo;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      ymin_in       = ymin_ff;
      ymax_in       = ymax_ff;
      den_in        = den_ff;
      status_in     = status_ff;
      prod_vld_in   = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff;
      div_start     = 1'b0;

      for (int k = 0; k < ANGLES; k++) begin
         prod_in[k]    = prod_ff[k];
         acc_in[k]     = prod_vld_ff ? acc_ff[k] + ACC_W'(prod_ff[k]) : acc_ff[k];
         rsp_ang_in[k] = rsp_ang_ff[k];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ram_we = store;
               if (req_last_point) begin
                  seen_in = '0;
                  if (seen_next != {PTS{1'b1}}) begin
                     status_in = hplr_pkg::STATUS_MISSING;
                     state_in  = ST_FINISH;
                  end else begin
                     sx_in    = '0;
                     sy_in    = '0;
                     ymin_in  = '1;
                     ymax_in  = '0;
                     cnt_in   = '0;
                     state_in = ST_SUM;
                  end
               end else begin
                  seen_in = seen_next;
               end
            end
         end
         ST_SUM: begin
            ram_re = (cnt_ff != SLOT_W'(PTS));
            if (cnt_ff != '0) begin
               sx_in = sx_ff + SUM_W'(rd_x);
               sy_in = sy_ff + SUM_W'(rd_y);
               if (rd_y < ymin_ff) begin
                  ymin_in = rd_y;
               end
               if (rd_y > ymax_ff) begin
                  ymax_in = rd_y;
               end
            end
            cnt_in = cnt_ff + SLOT_W'(1);
            if (cnt_ff == SLOT_W'(PTS)) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            cnt_in = '0;
            if (span == '0) begin
               status_in = hplr_pkg::STATUS_ZERO_SPAN;
               state_in  = ST_FINISH;
            end else begin
               status_in = hplr_pkg::STATUS_OK;
               den_in    = DEN_W'({span, 3'b000}) - DEN_W'(span);
               ram_re    = 1'b1;
               ram_raddr = '0;
               for (int k = 0; k < ANGLES; k++) begin
                  acc_in[k] = ACC_W'(coef_tbl[hplr_pkg::BIAS_ROW][k]) <<< hplr_pkg::NORM_FRAC;
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (res_x.done) begin
               state_in = ST_MAC_X;
            end
         end
         ST_MAC_X, ST_MAC_Y: begin
            prod_vld_in = 1'b1;
            for (int k = 0; k < ANGLES; k++) begin
               prod_in[k] = PROD_W'(vec_sel) * PROD_W'(coef_tbl[coef_row][k]);
            end
            if (state_ff == ST_MAC_X) begin
               state_in = ST_MAC_Y;
            end else if (cnt_ff == SLOT_W'(PTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in    = cnt_ff + SLOT_W'(1);
               ram_re    = 1'b1;
               ram_raddr = cnt_ff + SLOT_W'(1);
               state_in  = ST_START;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               for (int k = 0; k < ANGLES; k++) begin
                  rsp_ang_in[k] = (status_ff == hplr_pkg::STATUS_OK) ? ang_sat[k] : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // round half away from zero, then clamp to q9.7
   always_comb begin
      for (int k = 0; k < ANGLES; k++) begin
         rnd[k] = acc_ff[k] + HALF - ACC_W'(acc_ff[k][ACC_W-1]);
         shr[k] = rnd[k] >>> SH;
         if (shr[k] > ANG_MAX) begin
            ang_sat[k] = ANGLE_W'(ANG_MAX);
         end else if (shr[k] < ANG_MIN) begin
            ang_sat[k] = ANGLE_W'(ANG_MIN);
         end else begin
            ang_sat[k] = ANGLE_W'(shr[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         seen_ff      <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         seen_ff      <= seen_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      ymin_ff       <= ymin_in;
      ymax_ff       <= ymax_in;
      den_ff        <= den_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      for (int k = 0; k < ANGLES; k++) begin
         prod_ff[k]    <= prod_in[k];
         acc_ff[k]     <= acc_in[k];
         rsp_ang_ff[k] <= rsp_ang_in[k];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pitch  = rsp_ang_ff[0];
   assign rsp_yaw    = rsp_ang_ff[1];
   assign rsp_roll   = rsp_ang_ff[2];
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire
